[rtl/ctcp_pkg.sv]
// Shared types for the cell tile change plotter.
// Holds the configuration bundle and the classified tile record passed
// from the front end, through the queue, to the result generator.
package ctcp_pkg;

  typedef logic signed [3:0] zoom_t;

  typedef struct packed {
    zoom_t       zoom;
    logic [31:0] view_x;
    logic [31:0] view_y;
  } cfg_t;

  // One classified tile: grouped change mask, grouped live mask, offsets of
  // column 0 and row 0 from the view origin, the zoom in force and the
  // log2 of the row group size.
  typedef struct packed {
    logic [63:0] diff;
    logic [63:0] on;
    logic [31:0] dx0;
    logic [31:0] dy0;
    zoom_t       zoom;
    logic [1:0]  gshift;
  } tile_t;

endpackage

[rtl/ctcp_front.sv]
// Front end of the cell tile change plotter: takes a tile, groups its rows
// for the current zoom and queues the classified tile unless it is dropped.
// Depends on ctcp_pkg.
module ctcp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [31:0]    tile_x,
  input  logic [31:0]    tile_y,
  input  logic [63:0]    now_mask,
  input  logic [63:0]    before_mask,
  input  ctcp_pkg::cfg_t cfg,
  input  logic           q_full,
  output logic           push,
  output ctcp_pkg::tile_t push_data
);

  localparam ctcp_pkg::zoom_t ZOOM_PAIRS = -4'sd1;
  localparam ctcp_pkg::zoom_t ZOOM_FOURS = -4'sd2;
  localparam ctcp_pkg::zoom_t ZOOM_EIGHT = -4'sd3;

  logic        vld_r;
  logic [31:0] tx_r;
  logic [31:0] ty_r;
  logic [63:0] now_r;
  logic [63:0] bef_r;

  logic        accept;
  logic        drop;
  logic        done;
  logic [63:0] gn;
  logic [63:0] gb;
  logic [63:0] diff;
  logic [1:0]  gshift;
  logic [7:0]  n2 [4];
  logic [7:0]  b2 [4];
  logic [7:0]  n4 [2];
  logic [7:0]  b4 [2];
  logic [7:0]  n8;
  logic [7:0]  b8;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (done) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_r  <= tile_x;
      ty_r  <= tile_y;
      now_r <= now_mask;
      bef_r <= before_mask;
    end
  end

  // OR the rows together in pairs, fours and all eight.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      n2[i] = now_r[16*i +: 8] | now_r[16*i+8 +: 8];
      b2[i] = bef_r[16*i +: 8] | bef_r[16*i+8 +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      n4[i] = n2[2*i] | n2[2*i+1];
      b4[i] = b2[2*i] | b2[2*i+1];
    end
    n8 = n4[0] | n4[1];
    b8 = b4[0] | b4[1];
  end

  always_comb begin
    gn     = now_r;
    gb     = bef_r;
    gshift = 2'd0;
    if (cfg.zoom == ZOOM_PAIRS) begin
      gn     = {32'd0, n2[3], n2[2], n2[1], n2[0]};
      gb     = {32'd0, b2[3], b2[2], b2[1], b2[0]};
      gshift = 2'd1;
    end else if (cfg.zoom == ZOOM_FOURS) begin
      gn     = {48'd0, n4[1], n4[0]};
      gb     = {48'd0, b4[1], b4[0]};
      gshift = 2'd2;
    end else if (cfg.zoom == ZOOM_EIGHT) begin
      gn     = {56'd0, n8};
      gb     = {56'd0, b8};
      gshift = 2'd3;
    end
  end

  assign diff = gn ^ gb;
  // Tiles that change nothing, or zooms too far out, yield no results.
  assign drop = ($signed(cfg.zoom) < ZOOM_EIGHT) || (diff == 64'd0);
  assign push = vld_r && !drop && !q_full;
  assign done = vld_r && (drop || !q_full);
  assign busy = vld_r && !done;

  assign push_data.diff   = diff;
  assign push_data.on     = gn;
  assign push_data.dx0    = tx_r - cfg.view_x;
  assign push_data.dy0    = ty_r - cfg.view_y;
  assign push_data.zoom   = cfg.zoom;
  assign push_data.gshift = gshift;

endmodule

[rtl/ctcp_queue.sv]
// Two-entry queue of classified tiles between front end and result
// generator. Depends on ctcp_pkg.
module ctcp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ctcp_pkg::tile_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output ctcp_pkg::tile_t head
);

  ctcp_pkg::tile_t slot_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

endmodule

[rtl/ctcp_back.sv]
// Result generator: walks the change mask of one tile, one changed cell per
// cycle, and turns each into a point or square on screen.
// Depends on ctcp_pkg.
module ctcp_back #(
  parameter int SCREEN_COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ctcp_pkg::tile_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  output logic               out_turned_on,
  output logic               out_is_square,
  output logic signed [15:0] out_screen_x,
  output logic signed [15:0] out_screen_y,
  output logic [5:0]         out_side,
  output logic               out_last
);

  localparam int          CUT_W    = (SCREEN_COORD_BITS < 16) ? SCREEN_COORD_BITS : 16;
  localparam logic [16:0] CUT_FULL = (17'd1 << CUT_W) - 17'd1;
  localparam logic [15:0] CUT_MASK = CUT_FULL[15:0];

  function automatic logic [5:0] side_of(input ctcp_pkg::zoom_t z);
    logic [5:0] s;
    s = 6'd0;
    unique case (z) inside
      4'sd1:          s = 6'd2;
      4'sd2:          s = 6'd3;
      4'sd3:          s = 6'd7;
      4'sd4:          s = 6'd15;
      4'sd5:          s = 6'd31;
      4'sd6, 4'sd7:   s = 6'd63;
      default:        s = 6'd0;
    endcase
    return s;
  endfunction

  ctcp_pkg::tile_t cur_r;
  logic            cur_vld_r;
  logic [63:0]     mask_r;

  logic [63:0]     low;
  logic [63:0]     rest;
  logic [5:0]      idx;
  logic            last;
  logic            load;
  logic [5:0]      row_off;

  logic            s1_vld_r;
  logic            s1_on_r;
  logic            s1_last_r;
  logic [31:0]     s1_dx_r;
  logic [31:0]     s1_dy_r;
  ctcp_pkg::zoom_t s1_zoom_r;

  logic            sq;
  logic [3:0]      neg_z;
  logic [31:0]     sx;
  logic [31:0]     sy;

  // Isolate the lowest pending change and encode its cell index.
  always_comb begin
    low  = mask_r & (~mask_r + 64'd1);
    rest = mask_r & ~low;
    idx  = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (low[i]) begin
        idx = idx | 6'(i);
      end
    end
  end

  assign last  = (rest == 64'd0);
  assign load  = q_valid && (!cur_vld_r || last);
  assign q_pop = load;

  // Grouped row index times group size stays within the tile's eight rows.
  assign row_off = {3'd0, idx[5:3]} << cur_r.gshift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
    end else if (load) begin
      cur_vld_r <= 1'b1;
    end else if (cur_vld_r && last) begin
      cur_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r  <= q_data;
      mask_r <= q_data.diff;
    end else if (cur_vld_r) begin
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cur_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_on_r   <= cur_r.on[idx];
    s1_last_r <= last;
    s1_dx_r   <= cur_r.dx0 + {29'd0, idx[2:0]};
    s1_dy_r   <= cur_r.dy0 + {29'd0, row_off[2:0]};
    s1_zoom_r <= cur_r.zoom;
  end

  always_comb begin
    sq    = (s1_zoom_r > 4'sd0);
    neg_z = 4'(-s1_zoom_r);
    if (sq) begin
      sx = s1_dx_r << s1_zoom_r[2:0];
      sy = s1_dy_r << s1_zoom_r[2:0];
    end else begin
      sx = s1_dx_r >> neg_z[1:0];
      sy = s1_dy_r >> neg_z[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_turned_on <= s1_on_r;
    out_is_square <= sq;
    out_screen_x  <= $signed(sx[15:0] & CUT_MASK);
    out_screen_y  <= $signed(sy[15:0] & CUT_MASK);
    out_side      <= side_of(s1_zoom_r);
    out_last      <= s1_last_r;
  end

endmodule

[rtl/cell_tile_change_plotter_top.sv]
// Results pass the front-end register, the queue, the current-tile register,
// the s1 stage and the output register. Throughput: one result per cycle while
// the generator holds a tile; a tile gives one result per changed cell, and one
// with no change is dropped by the front end. A two-tile queue decouples the
// two ends. Reset (rst_n, synchronous) clears zoom and view origin to zero and
// empties the pipeline; results cannot be held off by the receiver.
module cell_tile_change_plotter_top #(
  parameter int SCREEN_COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_tile_x,
  input  logic [31:0]        in_tile_y,
  input  logic [63:0]        in_now_mask,
  input  logic [63:0]        in_before_mask,
  output logic               out_valid,
  output logic               out_turned_on,
  output logic               out_is_square,
  output logic signed [15:0] out_screen_x,
  output logic signed [15:0] out_screen_y,
  output logic [5:0]         out_side,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] REG_ZOOM   = 2'd0;
  localparam logic [1:0] REG_VIEW_X = 2'd1;
  localparam logic [1:0] REG_VIEW_Y = 2'd2;

  ctcp_pkg::zoom_t zoom_r;
  logic [31:0]     view_x_r;
  logic [31:0]     view_y_r;
  ctcp_pkg::cfg_t  cfg;
  logic            wr_en;

  ctcp_pkg::tile_t push_data;
  ctcp_pkg::tile_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r   <= 4'sd0;
      view_x_r <= 32'd0;
      view_y_r <= 32'd0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ZOOM:   zoom_r   <= $signed(pwdata[3:0]);
        REG_VIEW_X: view_x_r <= pwdata;
        REG_VIEW_Y: view_y_r <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ZOOM:   prdata = 32'($signed(zoom_r));
      REG_VIEW_X: prdata = view_x_r;
      REG_VIEW_Y: prdata = view_y_r;
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg.zoom   = zoom_r;
  assign cfg.view_x = view_x_r;
  assign cfg.view_y = view_y_r;

  ctcp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .tile_x      (in_tile_x),
    .tile_y      (in_tile_y),
    .now_mask    (in_now_mask),
    .before_mask (in_before_mask),
    .cfg         (cfg),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  ctcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  ctcp_back #(
    .SCREEN_COORD_BITS (SCREEN_COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (head),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_turned_on (out_turned_on),
    .out_is_square (out_is_square),
    .out_screen_x  (out_screen_x),
    .out_screen_y  (out_screen_y),
    .out_side      (out_side),
    .out_last      (out_last)
  );

endmodule

[tb/ctcp_change_checker.sv]
// Checker for the cell tile change plotter: follows the register writes on the configuration
// port, works out the changed cells of every accepted tile and compares the result stream.
// Depends on ctcp_pkg for the zoom type; register addresses are handed in by the testbench.
module ctcp_change_checker #(
  parameter int         SCREEN_COORD_BITS = 16,
  parameter logic [3:0] ADDR_ZOOM         = 4'h0,
  parameter logic [3:0] ADDR_VIEW_X       = 4'h4,
  parameter logic [3:0] ADDR_VIEW_Y       = 4'h8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [31:0]        in_tile_x,
  input  logic [31:0]        in_tile_y,
  input  logic [63:0]        in_now_mask,
  input  logic [63:0]        in_before_mask,
  input  logic               out_valid,
  input  logic               out_turned_on,
  input  logic               out_is_square,
  input  logic signed [15:0] out_screen_x,
  input  logic signed [15:0] out_screen_y,
  input  logic [5:0]         out_side,
  input  logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 fails,
  output int                 pending,
  output int                 compared
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        turned_on;
    logic        is_square;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    logic [5:0]  side;
    logic        last;
  } cell_change_t;

  ctcp_pkg::zoom_t zoom;
  logic [31:0]     view_x;
  logic [31:0]     view_y;
  cell_change_t    changes_due[$];
  cell_change_t    want;

  function automatic logic [15:0] screen_cut(input logic [31:0] v);
    logic [31:0] keep;
    keep = (SCREEN_COORD_BITS >= 32) ? 32'hFFFF_FFFF
                                     : ((32'd1 << SCREEN_COORD_BITS) - 32'd1);
    return 16'(v & keep);
  endfunction

  // At negative zoom the rows of a group are ORed before the comparison, and each
  // group is placed at the y of its first row. The last change of a tile is held
  // back until the tile is done so that it can carry the last flag.
  task automatic plot_tile_changes(input logic [31:0] tx, input logic [31:0] ty,
                                   input logic [63:0] now_m, input logic [63:0] was_m);
    int           z;
    int           group;
    int           rows;
    int           side_px;
    bit           square;
    bit           held_valid;
    logic [7:0]   line;
    logic [7:0]   old_line;
    logic [7:0]   diff;
    logic [31:0]  dx;
    logic [31:0]  dy;
    logic [31:0]  sx;
    logic [31:0]  sy;
    cell_change_t held;
    z = zoom;
    held_valid = 1'b0;
    if (z < -3) return;
    square = (z > 0);
    group = (z < 0) ? (1 << -z) : 1;
    rows = 8 / group;
    side_px = 0;
    if (square) begin
      side_px = (1 << z) - ((z > 1) ? 1 : 0);
      if (side_px > 63) side_px = 63;
    end
    for (int r = 0; r < rows; r++) begin
      line = '0;
      old_line = '0;
      for (int k = 0; k < group; k++) begin
        line |= now_m[((r * group + k) % 8) * 8 +: 8];
        old_line |= was_m[((r * group + k) % 8) * 8 +: 8];
      end
      diff = line ^ old_line;
      dy = ty + 32'(r * group) - view_y;
      sy = square ? (dy << z) : (dy >> -z);
      for (int c = 0; c < 8; c++) begin
        if (diff[c]) begin
          dx = tx + 32'(c) - view_x;
          sx = square ? (dx << z) : (dx >> -z);
          if (held_valid) changes_due.push_back(held);
          held.turned_on = line[c];
          held.is_square = square;
          held.screen_x = screen_cut(sx);
          held.screen_y = screen_cut(sy);
          held.side = 6'(side_px);
          held.last = 1'b0;
          held_valid = 1'b1;
        end
      end
    end
    if (held_valid) begin
      held.last = 1'b1;
      changes_due.push_back(held);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    fails++;
    $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      zoom = '0;
      view_x = '0;
      view_y = '0;
      changes_due.delete();
      fails = 0;
      compared = 0;
    end else begin
      if (out_valid) begin
        if (changes_due.size() == 0) begin
          report_mismatch("result with no change due", 32'd0, {out_screen_y, out_screen_x});
        end else begin
          want = changes_due.pop_front();
          compared++;
          if (out_turned_on !== want.turned_on)
            report_mismatch("turned_on", 32'(want.turned_on), 32'(out_turned_on));
          if (out_is_square !== want.is_square)
            report_mismatch("is_square", 32'(want.is_square), 32'(out_is_square));
          if (out_screen_x !== want.screen_x)
            report_mismatch("screen_x", 32'(want.screen_x), 32'(out_screen_x));
          if (out_screen_y !== want.screen_y)
            report_mismatch("screen_y", 32'(want.screen_y), 32'(out_screen_y));
          if (out_side !== want.side)
            report_mismatch("side", 32'(want.side), 32'(out_side));
          if (out_last !== want.last)
            report_mismatch("last", 32'(want.last), 32'(out_last));
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            ADDR_ZOOM:   zoom = pwdata[3:0];
            ADDR_VIEW_X: view_x = pwdata;
            ADDR_VIEW_Y: view_y = pwdata;
            default: ;
          endcase
        end else begin
          case (paddr)
            ADDR_ZOOM: begin
              if (prdata[3:0] !== zoom)
                report_mismatch("zoom readback", 32'(zoom), 32'(prdata[3:0]));
            end
            ADDR_VIEW_X: begin
              if (prdata !== view_x) report_mismatch("view_x readback", view_x, prdata);
            end
            ADDR_VIEW_Y: begin
              if (prdata !== view_y) report_mismatch("view_y readback", view_y, prdata);
            end
            default: ;
          endcase
        end
      end
      if (start && !busy) plot_tile_changes(in_tile_x, in_tile_y, in_now_mask, in_before_mask);
    end
    pending <= changes_due.size();
  end

endmodule

[tb/cell_tile_change_plotter_top_tb.sv]
// Testbench top for the cell tile change plotter: clock, reset, register set-up over the
// configuration port and tile stimulus, with a stall watchdog and the final verdict.
// Depends on ctcp_pkg, cell_tile_change_plotter_top and ctcp_change_checker.
module cell_tile_change_plotter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] ADDR_ZOOM     = 4'h0;
  localparam logic [3:0] ADDR_VIEW_X   = 4'h4;
  localparam logic [3:0] ADDR_VIEW_Y   = 4'h8;
  localparam int         RANDOM_TILES  = 190;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 12;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        in_tile_x = '0;
  logic [31:0]        in_tile_y = '0;
  logic [63:0]        in_now_mask = '0;
  logic [63:0]        in_before_mask = '0;
  logic               out_valid;
  logic               out_turned_on;
  logic               out_is_square;
  logic signed [15:0] out_screen_x;
  logic signed [15:0] out_screen_y;
  logic [5:0]         out_side;
  logic               out_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fails;
  int pending;
  int compared;
  int stall_count = 0;
  int sender_idle_pct = 0;
  int tiles_sent = 0;
  int settings_used = 0;

  cell_tile_change_plotter_top #(.SCREEN_COORD_BITS(16)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_tile_x(in_tile_x), .in_tile_y(in_tile_y),
    .in_now_mask(in_now_mask), .in_before_mask(in_before_mask),
    .out_valid(out_valid), .out_turned_on(out_turned_on), .out_is_square(out_is_square),
    .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
    .out_side(out_side), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ctcp_change_checker #(
    .SCREEN_COORD_BITS(16),
    .ADDR_ZOOM(ADDR_ZOOM), .ADDR_VIEW_X(ADDR_VIEW_X), .ADDR_VIEW_Y(ADDR_VIEW_Y)
  ) i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_tile_x(in_tile_x), .in_tile_y(in_tile_y),
    .in_now_mask(in_now_mask), .in_before_mask(in_before_mask),
    .out_valid(out_valid), .out_turned_on(out_turned_on), .out_is_square(out_is_square),
    .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
    .out_side(out_side), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fails(fails), .pending(pending), .compared(compared)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Any accepted item, result or register access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count == STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // psel stays high between back-to-back accesses; the caller drops it afterwards.
  task automatic apb_access(input logic [3:0] addr, input logic write, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_view(input ctcp_pkg::zoom_t z, input logic [31:0] vx,
                          input logic [31:0] vy);
    apb_access(ADDR_ZOOM, 1'b1, {28'($urandom), z});
    apb_access(ADDR_VIEW_X, 1'b1, vx);
    apb_access(ADDR_VIEW_Y, 1'b1, vy);
    apb_access(ADDR_ZOOM, 1'b0, '0);
    apb_access(ADDR_VIEW_X, 1'b0, '0);
    apb_access(ADDR_VIEW_Y, 1'b0, '0);
    psel <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  task automatic send_tile(input logic [31:0] tx, input logic [31:0] ty,
                           input logic [63:0] now_m, input logic [63:0] was_m);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_tile_x <= tx;
    in_tile_y <= ty;
    in_now_mask <= now_m;
    in_before_mask <= was_m;
    do @(posedge clk); while (busy);
    tiles_sent++;
  endtask

  // A tile with no change leaves no trace in the pending count, so after the last
  // result a further settling wait lets such a tile clear the pipeline.
  task automatic wait_idle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_mask();
    return {$urandom, $urandom};
  endfunction

  initial begin
    ctcp_pkg::zoom_t z;
    logic [31:0]     vx;
    logic [31:0]     vy;
    logic [31:0]     tx;
    logic [31:0]     ty;
    logic [63:0]     now_m;
    logic [63:0]     was_m;
    int              counted;
    int              n_tiles;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: plain view first, then every zoom the register can hold.
    sender_idle_pct = 18;
    set_view(ctcp_pkg::zoom_t'(0), 32'd0, 32'd0);
    send_tile(32'd0, 32'd0, 64'd0, 64'd0);
    send_tile($urandom, $urandom, '1, '0);
    send_tile($urandom, $urandom, '0, '1);
    send_tile(32'd16, 32'd24, 64'h1, 64'h80);
    send_tile('1, '1, 64'hAA55_AA55_AA55_AA55, 64'h55AA_55AA_55AA_55AA);
    send_tile($urandom, $urandom, '1, '1);
    wait_idle();
    set_view(ctcp_pkg::zoom_t'(0), '1, '1);
    send_tile(32'd0, 32'd0, 64'h8000_0000_0000_0001, 64'd0);
    for (int zi = -8; zi <= 7; zi++) begin
      wait_idle();
      set_view(ctcp_pkg::zoom_t'(zi), $urandom_range(255), $urandom_range(255));
      send_tile($urandom_range(511), $urandom_range(511), rand_mask(), rand_mask());
    end

    // Random part: one register setting per phase, mostly tiles near the view.
    counted = 0;
    while (counted < RANDOM_TILES) begin
      if ($urandom_range(99) < 12) z = ctcp_pkg::zoom_t'(-4 - int'($urandom_range(4)));
      else z = ctcp_pkg::zoom_t'(int'($urandom_range(10)) - 3);
      case ($urandom_range(3))
        0: vx = '0;
        1: vx = '1;
        default: vx = $urandom;
      endcase
      case ($urandom_range(3))
        0: vy = '0;
        1: vy = '1;
        default: vy = $urandom;
      endcase
      wait_idle();
      set_view(z, vx, vy);
      // Below zoom -3 the block shows nothing, so only a handful of tiles go in.
      n_tiles = (z < -3) ? 4 : int'($urandom_range(12, 28));
      for (int i = 0; i < n_tiles; i++) begin
        if (counted < RANDOM_TILES / 3) sender_idle_pct = 18;
        else if (counted < 2 * RANDOM_TILES / 3) sender_idle_pct = 59;
        else sender_idle_pct = 0;
        if ($urandom_range(9) < 7) begin
          tx = vx + 32'(int'($urandom_range(400)) - 200);
          ty = vy + 32'(int'($urandom_range(400)) - 200);
        end else begin
          tx = $urandom;
          ty = $urandom;
        end
        now_m = rand_mask();
        case ($urandom_range(9))
          0: was_m = now_m;
          1, 2, 3, 4, 5: was_m = now_m ^ (rand_mask() & rand_mask() & rand_mask());
          6, 7, 8: was_m = rand_mask();
          default: begin
            now_m = $urandom_range(1) ? '1 : '0;
            was_m = rand_mask();
          end
        endcase
        send_tile(tx, ty, now_m, was_m);
        if (z >= -3) counted++;
      end
    end
    wait_idle();

    $display("Sent %0d tiles under %0d register settings, zoom -8 to 7; %0d cell changes compared.",
             tiles_sent, settings_used, compared);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
